[rtl/wcg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_pkg: shared types, constants and sine-table function for the chirp generator
// Window modes, register indexes, the quarter sine table function and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package wcg_pkg;

   localparam int INDEX_BITS_DEF      = 16;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int CSR_ADDR_BITS       = 3;
   localparam int CSR_DATA_BITS       = 32;

   localparam logic [CSR_ADDR_BITS-1:0] REG_SAMPLE_COUNT   = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_CHIRP_RATE     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HALF_BANDWIDTH = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_WINDOW_MODE    = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLACKMAN_STEP  = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_HAMMING_STEP   = 3'd5;

   localparam logic [1:0] WIN_NONE     = 2'd0;
   localparam logic [1:0] WIN_BLACKMAN = 2'd1;
   localparam logic [1:0] WIN_HAMMING  = 2'd2;

   localparam logic [15:0] SAMPLE_COUNT_RST = 16'd1023;

   // Window coefficients, Q15
   localparam logic signed [17:0] BLK_A0 = 18'sd13763;
   localparam logic signed [17:0] BLK_A1 = 18'sd16384;
   localparam logic signed [17:0] BLK_A2 = 18'sd2621;
   localparam logic signed [17:0] HAM_A0 = 18'sd17695;
   localparam logic signed [17:0] HAM_A1 = 18'sd15073;

   // Controller to datapath
   typedef struct packed {
      logic load;   // capture a new sample index
      logic step;   // advance pipeline one stage
   } wcg_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic done;   // final stage holds a finished sample
   } wcg_sts_type;

   // First-quadrant sine, Q30 polynomial, evaluated at elaboration for tables
   function automatic logic [15:0] quad_sine(input int unsigned r, input int tbits);
      longint unsigned x, x2, a, s, v;
      x  = (longint'(r) * 64'd1686629713) >> (tbits - 2);
      x2 = (x * x) >> 30;
      a  = 64'd1073741824 - x2 / 72;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 42;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 20;
      a  = 64'd1073741824 - ((x2 * a) >> 30) / 6;
      s  = (x * a) >> 30;
      v  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

endpackage

[rtl/wcg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_ctrl: sequencer for the chirp generator
// Takes one request word, runs it through the datapath stages, holds the
// result until the response side takes it.
// ----------------------------------------------------------------------------
module wcg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output wcg_pkg::wcg_cmd_type cmd,
   input  wcg_pkg::wcg_sts_type sts
);
   import wcg_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            if (sts.done) begin
               cmd.step     = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/wcg_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_datapath: phase, sine lookup and window arithmetic
// Stage counter walks the multiplies and the shared sine table through the steps
// of one sample; position state lives here.
// ----------------------------------------------------------------------------
module wcg_datapath #(
   parameter int INDEX_BITS      = wcg_pkg::INDEX_BITS_DEF,
   parameter int SINE_TABLE_BITS = wcg_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wcg_pkg::wcg_cmd_type cmd,
   output wcg_pkg::wcg_sts_type sts,
   input  logic                 restart,
   input  logic [15:0]          sample_count,
   input  logic [31:0]          chirp_rate,
   input  logic [31:0]          half_bandwidth,
   input  logic [1:0]           window_mode,
   input  logic [31:0]          blackman_step,
   input  logic [31:0]          hamming_step,
   output logic signed [15:0]   in_phase,
   output logic signed [15:0]   quadrature,
   output logic [15:0]          position,
   output logic                 last_sample,
   output logic                 even_count_error
);
   import wcg_pkg::*;

   localparam int QB    = SINE_TABLE_BITS - 2;
   localparam int QSIZE = 1 << QB;

   // Quarter-wave table, logic constant
   logic [15:0] qtab [QSIZE+1];
   for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
      assign qtab[g] = quad_sine(g, SINE_TABLE_BITS);
   end

   function automatic logic signed [16:0] sine_of(input logic [31:0] ph,
                                                 input logic [15:0] tab [QSIZE+1]);
      logic [SINE_TABLE_BITS-1:0] t;
      logic [QB-1:0]              r;
      logic [QB:0]                idx;
      logic signed [16:0]         v;
      t   = ph[31 -: SINE_TABLE_BITS];
      r   = t[QB-1:0];
      idx = t[QB] ? ((QB+1)'(QSIZE) - {1'b0, r}) : {1'b0, r};
      v   = signed'({1'b0, tab[idx]});
      return t[QB+1] ? -v : v;
   endfunction

   // Sample index state
   logic [INDEX_BITS-1:0] pos_ff;
   logic [15:0]           k_ff;
   logic                  last_ff, err_ff;
   logic [2:0]            stage_ff;
   logic [31:0]           freq_ff, phase_ff, wph_ff;
   logic signed [16:0]    iv_ff, qv_ff, c1_ff, c2_ff;
   logic signed [47:0]    acc_ff;
   logic [15:0]           w_ff;
   logic signed [15:0]    iout_ff, qout_ff;

   logic [INDEX_BITS-1:0] kin;
   logic [15:0]           kcl;
   logic [31:0]           kx, mid;
   logic                  last_in;

   always_comb begin
      kin = restart ? '0 : pos_ff;
      kcl = ({{(32-INDEX_BITS){1'b0}}, kin} >= {16'd0, sample_count}) ? 16'd0
            : 16'(kin);
      last_in = (sample_count != 16'd0) && ({1'b0, kcl} + 17'd1 == {1'b0, sample_count});
   end

   assign kx  = {16'd0, k_ff};
   assign mid = {17'd0, sample_count[15:1]};

   // Window sum clamp
   logic signed [47:0] wsum;
   logic [15:0]        wcl;
   always_comb begin
      wsum = acc_ff + 48'sd16384;
      if (wsum < 0) wcl = 16'd0;
      else if ((wsum >>> 15) > 48'sd32767) wcl = 16'd32767;
      else wcl = wsum[30:15];
   end

   function automatic logic signed [15:0] apply_w(input logic signed [16:0] v,
                                                 input logic [15:0] w);
      logic signed [34:0] p;
      p = v * signed'({1'b0, w}) + 35'sd16384;
      return p[30:15];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         stage_ff <= '0;
      end else if (cmd.load) begin
         k_ff     <= kcl;
         last_ff  <= last_in;
         err_ff   <= ~sample_count[0];
         pos_ff   <= last_in ? '0 : INDEX_BITS'({16'd0, kcl} + 32'd1);
         stage_ff <= 3'd1;
      end else if (cmd.step) begin
         stage_ff <= stage_ff + 3'd1;
         case (stage_ff)
            3'd1: begin
               freq_ff <= kx * chirp_rate - half_bandwidth;
               wph_ff  <= kx * ((window_mode == WIN_BLACKMAN) ? blackman_step
                                                              : hamming_step);
            end
            3'd2: phase_ff <= 32'd0 - (kx - mid) * freq_ff;
            3'd3: begin
               iv_ff <= sine_of(phase_ff + 32'h4000_0000, qtab);
               qv_ff <= sine_of(phase_ff, qtab);
               c1_ff <= sine_of(wph_ff + 32'h4000_0000, qtab);
               c2_ff <= sine_of({wph_ff[30:0], 1'b0} + 32'h4000_0000, qtab);
            end
            3'd4: begin
               if (window_mode == WIN_BLACKMAN)
                  acc_ff <= 48'(BLK_A0) * 48'sd32768 - 48'(BLK_A1) * 48'(c1_ff)
                            + 48'(BLK_A2) * 48'(c2_ff);
               else
                  acc_ff <= 48'(HAM_A0) * 48'sd32768 + 48'(HAM_A1) * 48'(c1_ff);
            end
            3'd5: w_ff <= wcl;
            3'd6: begin
               if (err_ff) begin
                  iout_ff <= '0;
                  qout_ff <= '0;
               end else if (window_mode == WIN_BLACKMAN || window_mode == WIN_HAMMING) begin
                  iout_ff <= apply_w(iv_ff, w_ff);
                  qout_ff <= apply_w(qv_ff, w_ff);
               end else begin
                  iout_ff <= iv_ff[15:0];
                  qout_ff <= qv_ff[15:0];
               end
            end
            default: ;
         endcase
      end else begin
         stage_ff <= (stage_ff == 3'd7) ? 3'd0 : stage_ff;
      end
   end

   assign sts.done         = (stage_ff == 3'd7);
   assign in_phase         = iout_ff;
   assign quadrature       = qout_ff;
   assign position         = k_ff;
   assign last_sample      = last_ff;
   assign even_count_error = err_ff;

endmodule

[rtl/windowed_chirp_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_chirp_generator_top: windowed linear-FM chirp sample generator
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_valid / req_stall / req_restart): each accepted word
//    asks for the next chirp sample; restart=1 starts again at sample zero.
//  - Response channel (rsp_valid / rsp_stall / rsp_*): one word per request:
//    windowed I and Q in Q1.15, sample position, last flag, even-count error.
//  - csr_write_enable / csr_index / csr_data write the six setup registers;
//    write only while no sample is in flight.
//  - One sample at a time: a new word is taken only once the last response
//    has left, as the steps of a sample run in turn over the shared sine
//    table.
//  - A stalled response holds its word; req_stall stays high until it leaves.
//  - Reset: position 0, sample_count 1023, other registers 0, no words held.
// ----------------------------------------------------------------------------
module windowed_chirp_generator_top #(
   parameter int INDEX_BITS      = wcg_pkg::INDEX_BITS_DEF,
   parameter int SINE_TABLE_BITS = wcg_pkg::SINE_TABLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [15:0]                 rsp_in_phase,
   output logic signed [15:0]                 rsp_quadrature,
   output logic [15:0]                        rsp_position,
   output logic                               rsp_last_sample,
   output logic                               rsp_even_count_error,
   input  logic                               csr_write_enable,
   input  logic [wcg_pkg::CSR_ADDR_BITS-1:0]  csr_index,
   input  logic [wcg_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import wcg_pkg::*;

   // Setup registers
   logic [15:0] sample_count_ff;
   logic [31:0] chirp_rate_ff, half_bandwidth_ff, blackman_step_ff, hamming_step_ff;
   logic [1:0]  window_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff   <= SAMPLE_COUNT_RST;
         chirp_rate_ff     <= '0;
         half_bandwidth_ff <= '0;
         window_mode_ff    <= WIN_NONE;
         blackman_step_ff  <= '0;
         hamming_step_ff   <= '0;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_SAMPLE_COUNT:   sample_count_ff   <= csr_data[15:0];
            REG_CHIRP_RATE:     chirp_rate_ff     <= csr_data;
            REG_HALF_BANDWIDTH: half_bandwidth_ff <= csr_data;
            REG_WINDOW_MODE:    window_mode_ff    <= csr_data[1:0];
            REG_BLACKMAN_STEP:  blackman_step_ff  <= csr_data;
            REG_HAMMING_STEP:   hamming_step_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   wcg_cmd_type cmd;
   wcg_sts_type sts;

   wcg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   wcg_datapath #(
      .INDEX_BITS      (INDEX_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .restart          (req_restart),
      .sample_count     (sample_count_ff),
      .chirp_rate       (chirp_rate_ff),
      .half_bandwidth   (half_bandwidth_ff),
      .window_mode      (window_mode_ff),
      .blackman_step    (blackman_step_ff),
      .hamming_step     (hamming_step_ff),
      .in_phase         (rsp_in_phase),
      .quadrature       (rsp_quadrature),
      .position         (rsp_position),
      .last_sample      (rsp_last_sample),
      .even_count_error (rsp_even_count_error)
   );

endmodule

[rtl/wcg_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wcg_checker: port-level checks for the chirp generator
// Response word stability and error-flag consistency.
// ----------------------------------------------------------------------------
module wcg_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_in_phase,
   input logic signed [15:0] rsp_quadrature,
   input logic               rsp_even_count_error
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_in_phase))
      else $error("response changed under stall");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_even_count_error |-> rsp_in_phase == 0 && rsp_quadrature == 0)
      else $error("nonzero sample with even count");
endmodule

bind windowed_chirp_generator_top wcg_checker u_chk (
   .clock                (clock),
   .reset                (reset),
   .req_stall            (req_stall),
   .rsp_valid            (rsp_valid),
   .rsp_stall            (rsp_stall),
   .rsp_in_phase         (rsp_in_phase),
   .rsp_quadrature       (rsp_quadrature),
   .rsp_even_count_error (rsp_even_count_error)
);
